>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CHD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CHD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/chd_pkg.sv
`default_nettype none
package chd_pkg;

   localparam int MAX_SPEAKERS = 64;
   localparam int MAX_ORDER    = 31;
   localparam int COEF_WIDTH   = 16;

   localparam int SPK_W  = 6;
   localparam int HARM_W = 6;
   localparam int CNT_W  = 7;
   localparam int ORD_W  = 5;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SPEAKER_COUNT  = 1'b0,
      CSR_HARMONIC_ORDER = 1'b1
   } csr_reg_type;

   // phase divider: numerator is (k*s) followed by 16 bits holding floor(N/2)
   localparam int DEG_W    = 6;
   localparam int PROD_W   = 12;
   localparam int PHASE_W  = 16;
   localparam int DIV_W    = 7;
   // amplitude divider: one quotient bit per cell
   localparam int QUO_W    = COEF_WIDTH + 1;
   localparam int SCALE_S  = 32 - COEF_WIDTH;
   localparam int DIV_WORD_W = (PROD_W + PHASE_W > QUO_W) ? (PROD_W + PHASE_W) : QUO_W;
   localparam int DIV1_STEPS = DIV_WORD_W;

   localparam int CORDIC_STEPS = 28;
   localparam int STEP_W       = 5;
   localparam int CW_W         = 34;

   localparam logic signed [CW_W-1:0] X_INIT = CW_W'(32'h26DD3B6A);

   localparam logic [QUO_W-1:0] POS_LIMIT = {2'b00, {(COEF_WIDTH-1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_LIMIT = {2'b01, {(COEF_WIDTH-1){1'b0}}};
   localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic err;
      logic odd;
      logic kz;
      logic flip;
      logic neg;
   } tag_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic [DIV_W-1:0]      divisor;
      logic [DIV_W-1:0]      rem;
      logic [DIV_WORD_W-1:0] word;
   } div_lane_type;

   typedef struct packed {
      logic                   valid;
      tag_type                tag;
      logic signed [CW_W-1:0] x;
      logic signed [CW_W-1:0] y;
      logic signed [CW_W-1:0] z;
   } cordic_lane_type;

   typedef struct packed {
      logic                  valid;
      logic [COEF_WIDTH-1:0] coef;
      logic                  err;
   } res_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] step);
      logic [31:0] a;
      case (step)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/chd_if.sv
`default_nettype none
interface chd_req_if;
   logic                       valid;
   logic                       ready;
   logic [chd_pkg::SPK_W-1:0]  speaker_index;
   logic [chd_pkg::HARM_W-1:0] harmonic_index;
   modport source (output valid, output speaker_index, output harmonic_index, input ready);
   modport sink (input valid, input speaker_index, input harmonic_index, output ready);
endinterface

interface chd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [chd_pkg::COEF_WIDTH-1:0] coefficient;
   logic                                  index_error;
   modport source (output valid, output coefficient, output index_error, input ready);
   modport sink (input valid, input coefficient, input index_error, output ready);
endinterface

interface chd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [chd_pkg::CSR_ADDR_W-1:0] index;
   logic [chd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/chd_div_cell.sv
`default_nettype none
`include "assert_macros.svh"
// One restoring division step: shift one numerator bit into the remainder,
// subtract the divisor when it fits, shift the quotient bit into the word.
module chd_div_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   enable,
   input  chd_pkg::div_lane_type in_lane,
   output chd_pkg::div_lane_type out_lane
);

   chd_pkg::div_lane_type lane_ff, lane_in;
   logic [chd_pkg::DIV_W-1:0] rem2;
   logic                      fits;

   always_comb begin
      rem2 = {in_lane.rem[chd_pkg::DIV_W-2:0], in_lane.word[chd_pkg::DIV_WORD_W-1]};
      fits = (rem2 >= in_lane.divisor);
      lane_in = in_lane;
      lane_in.rem = fits ? (rem2 - in_lane.divisor) : rem2;
      lane_in.word = {in_lane.word[chd_pkg::DIV_WORD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane = lane_ff;

   `CHD_ASSERT_IMP(a_rem_below_divisor, clock, reset, lane_ff.valid,
      lane_ff.rem < lane_ff.divisor, "division remainder not below divisor")

endmodule
`default_nettype wire

>>> hw/rtl/chd_cordic_cell.sv
`default_nettype none
`include "assert_macros.svh"
// One CORDIC rotation; step is tied to the cell's place in the row.
module chd_cordic_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         enable,
   input  wire [chd_pkg::STEP_W-1:0]   step,
   input  chd_pkg::cordic_lane_type    in_lane,
   output chd_pkg::cordic_lane_type    out_lane
);

   chd_pkg::cordic_lane_type lane_ff, lane_in;
   logic signed [chd_pkg::CW_W-1:0] x_cur, y_cur, x_sh, y_sh, atan_s;

   always_comb begin
      x_cur  = in_lane.x;
      y_cur  = in_lane.y;
      x_sh   = x_cur >>> step;
      y_sh   = y_cur >>> step;
      atan_s = $signed({2'b00, chd_pkg::atan_turn(step)});
      lane_in = in_lane;
      if (!in_lane.z[chd_pkg::CW_W-1]) begin
         lane_in.x = x_cur - y_sh;
         lane_in.y = y_cur + x_sh;
         lane_in.z = in_lane.z - atan_s;
      end else begin
         lane_in.x = x_cur + y_sh;
         lane_in.y = y_cur - x_sh;
         lane_in.z = in_lane.z + atan_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane = lane_ff;

   // residual angle never leaves a quarter turn either side
   `CHD_ASSERT_IMP(a_angle_bounded, clock, reset, lane_ff.valid,
      (lane_ff.z <= $signed(34'sh040000000)) && (lane_ff.z >= $signed(-34'sh040000000)),
      "CORDIC residual angle out of range")

endmodule
`default_nettype wire

>>> hw/rtl/chd_out_buf.sv
`default_nettype none
`include "assert_macros.svh"
// Output register plus skid entry; the pipeline advances while the skid is empty.
module chd_out_buf (
   input  wire              clock,
   input  wire              reset,
   input  chd_pkg::res_type res,
   output logic             advance,
   chd_rsp_if.source        rsp_chan
);

   logic                           out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic [chd_pkg::COEF_WIDTH-1:0] out_coef_ff, out_coef_in, skid_coef_ff, skid_coef_in;
   logic                           out_err_ff, out_err_in, skid_err_ff, skid_err_in;
   logic                           pop, push;

   assign advance = !skid_v_ff;
   assign pop     = out_v_ff && rsp_chan.ready;
   assign push    = res.valid && advance;

   always_comb begin
      out_v_in     = out_v_ff;
      out_coef_in  = out_coef_ff;
      out_err_in   = out_err_ff;
      skid_v_in    = skid_v_ff;
      skid_coef_in = skid_coef_ff;
      skid_err_in  = skid_err_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_coef_in = skid_coef_ff;
            out_err_in  = skid_err_ff;
            skid_v_in   = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_v_in    = 1'b1;
            out_coef_in = res.coef;
            out_err_in  = res.err;
         end else begin
            // hold the new item aside until the output drains
            skid_v_in    = 1'b1;
            skid_coef_in = res.coef;
            skid_err_in  = res.err;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_coef_ff  <= out_coef_in;
      out_err_ff   <= out_err_in;
      skid_coef_ff <= skid_coef_in;
      skid_err_ff  <= skid_err_in;
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.coefficient = $signed(out_coef_ff);
   assign rsp_chan.index_error = out_err_ff;

   `CHD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff,
      "skid entry held without an output item")
   `CHD_ASSERT_NXT(a_skid_kept, clock, reset, skid_v_ff && !rsp_chan.ready, skid_v_ff,
      "skid entry dropped while output stalled")

endmodule
`default_nettype wire

>>> hw/rtl/circular_harmonic_decoder_coeff_core.sv
// A request item passes the entry stage, phase divider, CORDIC row, amplitude
// divider and output register. Throughput: one item per cycle while req ready
// is high; the rows are fully pipelined, one cell per quotient bit or rotation.
// Two stalled response items fill the output buffer and drop req ready.
// Reset (synchronous, active high) empties the pipeline and sets the speaker
// count to 8 and the order to 1; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module circular_harmonic_decoder_coeff_core (
   input  wire       clock,
   input  wire       reset,
   chd_req_if.sink   req_chan,
   chd_rsp_if.source rsp_chan,
   chd_csr_if.sink   csr_chan
);

   logic [chd_pkg::CNT_W-1:0] spk_count_ff;
   logic [chd_pkg::ORD_W-1:0] order_ff;

   logic                       en;
   logic [chd_pkg::ORD_W-1:0]  ord_sat;
   logic [chd_pkg::HARM_W-1:0] nharm;
   logic [chd_pkg::CNT_W-1:0]  n_sat, n_eff;
   logic                       accept;
   logic [chd_pkg::DEG_W-1:0]  deg;
   logic [chd_pkg::PROD_W-1:0] prod;

   chd_pkg::div_lane_type    div1_ff, div1_in;
   chd_pkg::div_lane_type    div1_link [0:chd_pkg::DIV1_STEPS];
   chd_pkg::cordic_lane_type cord_ff, cord_in;
   chd_pkg::cordic_lane_type cord_link [0:chd_pkg::CORDIC_STEPS];
   chd_pkg::div_lane_type    div2_ff, div2_in;
   chd_pkg::div_lane_type    div2_link [0:chd_pkg::QUO_W];
   chd_pkg::res_type         res;

   logic [chd_pkg::PHASE_W-1:0]     phase, phase_rot;
   logic                            flip;
   logic signed [chd_pkg::CW_W-1:0] v_sel, v_fin;
   logic [chd_pkg::CW_W-1:0]        mag, half, m_sum;
   logic [chd_pkg::ORD_W:0]         d_base;
   logic [chd_pkg::DIV_W-1:0]       d_scale;
   logic [chd_pkg::QUO_W-1:0]       quo, quo_neg;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spk_count_ff <= chd_pkg::CNT_W'(8);
         order_ff     <= chd_pkg::ORD_W'(1);
      end else if (csr_chan.valid) begin
         case (chd_pkg::csr_reg_type'(csr_chan.index))
            chd_pkg::CSR_SPEAKER_COUNT:  spk_count_ff <= csr_chan.data[chd_pkg::CNT_W-1:0];
            chd_pkg::CSR_HARMONIC_ORDER: order_ff <= csr_chan.data[chd_pkg::ORD_W-1:0];
            default: ;
         endcase
      end
   end

   // effective speaker count and harmonic count
   always_comb begin
      ord_sat = (order_ff > chd_pkg::ORD_W'(chd_pkg::MAX_ORDER)) ?
                chd_pkg::ORD_W'(chd_pkg::MAX_ORDER) : order_ff;
      nharm   = {ord_sat, 1'b1};
      n_sat   = (spk_count_ff > chd_pkg::CNT_W'(chd_pkg::MAX_SPEAKERS)) ?
                chd_pkg::CNT_W'(chd_pkg::MAX_SPEAKERS) : spk_count_ff;
      n_eff   = (n_sat < {1'b0, nharm}) ? {1'b0, nharm} : n_sat;
   end

   // entry stage: degree, product and phase numerator
   assign req_chan.ready = en;
   assign accept         = req_chan.valid && en;

   always_comb begin
      deg  = chd_pkg::DEG_W'(({1'b0, req_chan.harmonic_index} + 7'd1) >> 1);
      prod = chd_pkg::PROD_W'(deg) * chd_pkg::PROD_W'(req_chan.speaker_index);
      div1_in          = '0;
      div1_in.valid    = accept;
      div1_in.tag.err  = ({1'b0, req_chan.speaker_index} >= n_eff) ||
                         (req_chan.harmonic_index >= nharm);
      div1_in.tag.odd  = req_chan.harmonic_index[0];
      div1_in.tag.kz   = (deg == '0);
      div1_in.divisor  = n_eff;
      div1_in.word     = chd_pkg::DIV_WORD_W'({prod, chd_pkg::PHASE_W'(n_eff >> 1)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div1_ff.valid <= 1'b0;
      end else if (en) begin
         div1_ff <= div1_in;
      end
   end

   assign div1_link[0] = div1_ff;

   // phase = floor(((k*s) * 2^16 + N/2) / N) mod 2^16
   for (genvar i = 0; i < chd_pkg::DIV1_STEPS; i++) begin : g_div1
      chd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .in_lane  (div1_link[i]),
         .out_lane (div1_link[i+1])
      );
   end

   // fold the angle into the right half plane
   always_comb begin
      phase     = div1_link[chd_pkg::DIV1_STEPS].word[chd_pkg::PHASE_W-1:0];
      flip      = phase[chd_pkg::PHASE_W-1] ^ phase[chd_pkg::PHASE_W-2];
      phase_rot = {phase[chd_pkg::PHASE_W-1] ^ flip, phase[chd_pkg::PHASE_W-2:0]};
      cord_in          = '0;
      cord_in.valid    = div1_link[chd_pkg::DIV1_STEPS].valid;
      cord_in.tag      = div1_link[chd_pkg::DIV1_STEPS].tag;
      cord_in.tag.flip = flip;
      cord_in.x        = chd_pkg::X_INIT;
      cord_in.y        = '0;
      cord_in.z        = $signed({{(chd_pkg::CW_W-32){phase_rot[chd_pkg::PHASE_W-1]}},
                                  phase_rot, 16'h0000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cord_ff.valid <= 1'b0;
      end else if (en) begin
         cord_ff <= cord_in;
      end
   end

   assign cord_link[0] = cord_ff;

   for (genvar i = 0; i < chd_pkg::CORDIC_STEPS; i++) begin : g_cordic
      chd_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .step     (chd_pkg::STEP_W'(i)),
         .in_lane  (cord_link[i]),
         .out_lane (cord_link[i+1])
      );
   end

   // magnitude and rounding offset for the amplitude divider
   always_comb begin
      v_sel   = cord_link[chd_pkg::CORDIC_STEPS].tag.odd ?
                cord_link[chd_pkg::CORDIC_STEPS].y : cord_link[chd_pkg::CORDIC_STEPS].x;
      v_fin   = cord_link[chd_pkg::CORDIC_STEPS].tag.flip ? -v_sel : v_sel;
      mag     = v_fin[chd_pkg::CW_W-1] ? (~v_fin + 1'b1) : v_fin;
      d_base  = {1'b0, ord_sat} + 1'b1;
      d_scale = cord_link[chd_pkg::CORDIC_STEPS].tag.kz ? {d_base, 1'b0} : {1'b0, d_base};
      half    = (chd_pkg::CW_W'(d_scale) << chd_pkg::SCALE_S) >> 1;
      m_sum   = {mag[chd_pkg::CW_W-2:0], 1'b0} + half;
      div2_in         = '0;
      div2_in.valid   = cord_link[chd_pkg::CORDIC_STEPS].valid;
      div2_in.tag     = cord_link[chd_pkg::CORDIC_STEPS].tag;
      div2_in.tag.neg = v_fin[chd_pkg::CW_W-1];
      div2_in.divisor = d_scale;
      div2_in.word    = chd_pkg::DIV_WORD_W'(m_sum[chd_pkg::SCALE_S +: chd_pkg::QUO_W])
                        << (chd_pkg::DIV_WORD_W - chd_pkg::QUO_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div2_ff.valid <= 1'b0;
      end else if (en) begin
         div2_ff <= div2_in;
      end
   end

   assign div2_link[0] = div2_ff;

   for (genvar i = 0; i < chd_pkg::QUO_W; i++) begin : g_div2
      chd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .in_lane  (div2_link[i]),
         .out_lane (div2_link[i+1])
      );
   end

   // sign, saturate, force zero on a bad index
   always_comb begin
      quo       = div2_link[chd_pkg::QUO_W].word[chd_pkg::QUO_W-1:0];
      quo_neg   = ~quo + 1'b1;
      res.valid = div2_link[chd_pkg::QUO_W].valid;
      res.err   = div2_link[chd_pkg::QUO_W].tag.err;
      if (div2_link[chd_pkg::QUO_W].tag.err) begin
         res.coef = '0;
      end else if (div2_link[chd_pkg::QUO_W].tag.neg) begin
         res.coef = (quo > chd_pkg::NEG_LIMIT) ? chd_pkg::COEF_MIN :
                    quo_neg[chd_pkg::COEF_WIDTH-1:0];
      end else begin
         res.coef = (quo > chd_pkg::POS_LIMIT) ? chd_pkg::COEF_MAX :
                    quo[chd_pkg::COEF_WIDTH-1:0];
      end
   end

   chd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .advance  (en),
      .rsp_chan (rsp_chan)
   );

   `CHD_ASSERT_IMP(a_error_gives_zero, clock, reset, rsp_chan.valid && rsp_chan.index_error,
      rsp_chan.coefficient == '0, "index error with nonzero coefficient")

endmodule
`default_nettype wire
